// ----- rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the partition fit allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

  // fixed field widths of the transaction ports
  localparam int SLOT_W = 3;
  localparam int SIZE_W = 16;
  localparam int PART_W = 3;

  // defaults for the top-level parameters
  localparam int DEF_NUM_PARTITIONS = 8;
  localparam int DEF_SIZE_BITS      = 16;

  // command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // transaction kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // fit rules
  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  // classified command as it sits in the queue
  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic [SIZE_W-1:0] size;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/pfa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_front
// accepts commands, checks the load slot range and queues them for the back
// ----------------------------------------------------------------------------
module pfa_front #(
  parameter int NUM_PARTITIONS = pfa_pkg::DEF_NUM_PARTITIONS
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire                        kind,
  input  wire  [pfa_pkg::SLOT_W-1:0] slot,
  input  wire  [pfa_pkg::SIZE_W-1:0] size,
  output logic                       busy,
  output logic                       q_valid,
  output pfa_pkg::item_t             q_item,
  input  wire                        q_pop
);
  import pfa_pkg::*;

  item_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  item_t              in_item;

  // classify the incoming transaction
  always_comb begin
    in_item.kind    = kind;
    in_item.slot    = slot;
    in_item.slot_ok = (32'(slot) < NUM_PARTITIONS);
    in_item.size    = size;
  end

  assign busy    = (count == QCNT_W'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + QCNT_W'($past(push)) - QCNT_W'($past(q_pop)))
    else $error("queue count out of step with push and pop");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("pushed command not visible to the back");

endmodule
`default_nettype wire

// ----- rtl/pfa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_back
// executes queued commands against the capacity memory, scanning one entry per cycle
// ----------------------------------------------------------------------------
module pfa_back #(
  parameter int NUM_PARTITIONS = pfa_pkg::DEF_NUM_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [1:0]                 policy,
  input  wire                        q_valid,
  input  pfa_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       done,
  output logic                       granted,
  output logic [pfa_pkg::PART_W-1:0] partition,
  output logic [pfa_pkg::SIZE_W-1:0] leftover
);
  import pfa_pkg::*;

  localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CW = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam logic [IW-1:0] LAST = IW'(NUM_PARTITIONS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [SIZE_W-1:0]    req;
  logic [IW-1:0]        cur_pos;
  logic [IW-1:0]        cnt;
  logic                 found;
  logic [IW-1:0]        pick;
  logic [SIZE_BITS-1:0] pick_cap;
  logic [IW-1:0]        nptr;

  logic [SIZE_BITS-1:0] cap_mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] cap_vld;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_vld;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        start_pos;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  logic [SIZE_BITS-1:0] cap_eff;
  logic                 fits;
  logic                 take;
  logic [IW+PART_W-1:0] pick_ext;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == LAST) ? '0 : p + IW'(1);
  endfunction

  assign start_pos = (policy == POL_NEXT) ? nptr : '0;
  assign rd_addr   = (state == S_IDLE) ? start_pos : wrap_inc(cur_pos);
  assign q_pop     = (state == S_IDLE) && q_valid;

  // never-written entries read as zero capacity
  assign cap_eff = rd_vld ? rd_data : '0;
  assign fits    = CW'(cap_eff) >= CW'(req);

  always_comb begin
    case (policy)
      POL_BEST:  take = fits && (!found || cap_eff < pick_cap);
      POL_WORST: take = fits && (!found || cap_eff > pick_cap);
      default:   take = fits && !found;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick;
    wr_data = pick_cap - SIZE_BITS'(req);
    if (state == S_IDLE) begin
      wr_en   = q_valid && (q_item.kind == KIND_LOAD) && q_item.slot_ok;
      wr_addr = IW'(q_item.slot);
      wr_data = SIZE_BITS'(q_item.size);
    end else if (state == S_DONE) begin
      wr_en = found;
    end
  end

  assign pick_ext = {{PART_W{1'b0}}, pick};

  // capacity memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cap_mem[wr_addr] <= wr_data;
    end
    rd_data <= cap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        cap_vld[wr_addr] <= 1'b1;
      end
      rd_vld <= cap_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nptr  <= '0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == KIND_LOAD) begin
              nptr <= '0;
            end else begin
              req     <= q_item.size;
              cur_pos <= start_pos;
              cnt     <= '0;
              found   <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            found    <= 1'b1;
            pick     <= cur_pos;
            pick_cap <= cap_eff;
          end
          if (cnt == LAST) begin
            state <= S_DONE;
          end else begin
            cnt     <= cnt + IW'(1);
            cur_pos <= wrap_inc(cur_pos);
          end
        end
        S_DONE: begin
          granted   <= found;
          partition <= found ? pick_ext[PART_W-1:0] : '0;
          leftover  <= found ? SIZE_W'(wr_data) : '0;
          if (found && policy == POL_NEXT) begin
            nptr <= wrap_inc(pick);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("command taken while back is working");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE)
    else $error("result strobe without finished scan");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && $past(state) == S_IDLE) |-> cnt == '0)
    else $error("scan did not start at the first step");

endmodule
`default_nettype wire

// ----- rtl/partition_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// partition_fit_allocator
// capacity tracker for a fixed set of partitions with four fit rules
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low; a load
// transaction writes one partition capacity (if its slot is in range) and
// gives no result, a request transaction gives exactly one result, shown for
// a single cycle with done high, and the receiver cannot stall it. commands
// pass through a two-entry queue, so busy only rises when two commands are
// waiting. in the back, a load is written as it leaves the queue, and a
// request is scanned over the capacity memory: it has a single registered
// read port, so the scan reads one partition per cycle, then a final step
// writes back the charged capacity and registers the result. the result
// strobe appears in the cycle after that step. capacities reset to zero via
// per-entry valid bits, so there is no clearing pass after reset. policy
// may only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module partition_fit_allocator #(
  parameter int NUM_PARTITIONS = pfa_pkg::DEF_NUM_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
  input  wire                        clk,
  input  wire                        rst,
  // command side
  input  wire                        start,
  output logic                       busy,
  input  wire                        kind,
  input  wire  [pfa_pkg::SLOT_W-1:0] slot,
  input  wire  [pfa_pkg::SIZE_W-1:0] size,
  // result side
  output logic                       done,
  output logic                       granted,
  output logic [pfa_pkg::PART_W-1:0] partition,
  output logic [pfa_pkg::SIZE_W-1:0] leftover,
  // policy register write
  input  wire                        policy_wr,
  input  wire  [1:0]                 policy_data
);
  import pfa_pkg::*;

  logic [1:0] policy;   // fit rule, reset to best fit
  logic       q_valid;  // queue holds a command
  item_t      q_item;   // oldest queued command
  logic       q_pop;    // back takes the oldest command

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_BEST;
    end else if (policy_wr) begin
      policy <= policy_data;
    end
  end

  // front: classify and queue commands
  pfa_front #(
    .NUM_PARTITIONS(NUM_PARTITIONS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .kind    (kind),
    .slot    (slot),
    .size    (size),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back: capacity memory, scan and write-back
  pfa_back #(
    .NUM_PARTITIONS(NUM_PARTITIONS),
    .SIZE_BITS     (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .done      (done),
    .granted   (granted),
    .partition (partition),
    .leftover  (leftover)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the partition fit allocator: a directed table and
// random load/request traffic under all four fit rules, each result compared
// against its row's own expectation or an in-bench capacity and pointer tracker
// ----------------------------------------------------------------------------
module tb_top;

  import pfa_pkg::*;

  localparam int NPART        = DEF_NUM_PARTITIONS;
  localparam int DRAIN_CYCLES = 24;      // covers loads still in the queue
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SEGMENTS     = 10;      // policy settings per idling phase
  localparam int SEG_ITEMS    = 63;

  // what one directed row does
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_REQ,
    OP_POLICY
  } dir_op_e;

  typedef struct packed {
    logic              granted;
    logic [PART_W-1:0] partition;
    logic [SIZE_W-1:0] leftover;
  } alloc_result_t;

  // typed rows carry their own expectation, the others use the tracker
  typedef struct packed {
    dir_op_e           op;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic              typed;
    logic              w_granted;
    logic [PART_W-1:0] w_partition;
    logic [SIZE_W-1:0] w_leftover;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty store right after reset
    '{OP_REQ,    3'd0, 16'd1,            1'b1, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd0,            1'b1, 1'b1, 3'd0, 16'd0},
    '{OP_LOAD,   3'd0, 16'd100,          1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_LOAD,   3'd1, 16'd40,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_LOAD,   3'd2, 16'd65535,        1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_LOAD,   3'd3, 16'd40,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_LOAD,   3'd7, 16'd1,            1'b0, 1'b0, 3'd0, 16'd0},
    // best fit with a tie between two equal partitions
    '{OP_REQ,    3'd0, 16'd30,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd65535,        1'b1, 1'b1, 3'd2, 16'd0},
    '{OP_REQ,    3'd0, 16'd65535,        1'b1, 1'b0, 3'd0, 16'd0},
    '{OP_POLICY, 3'd0, 16'(POL_FIRST),   1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd5,            1'b0, 1'b0, 3'd0, 16'd0},
    // next fit walks the pointer and wraps past the top
    '{OP_POLICY, 3'd0, 16'(POL_NEXT),    1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd10,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd10,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd20,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd50,           1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd60000,        1'b1, 1'b0, 3'd0, 16'd0},
    // a load also clears the next-fit pointer
    '{OP_LOAD,   3'd5, 16'd7,            1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_POLICY, 3'd0, 16'(POL_WORST),   1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd0,            1'b0, 1'b0, 3'd0, 16'd0},
    '{OP_REQ,    3'd0, 16'd36,           1'b1, 1'b0, 3'd0, 16'd0},
    '{OP_POLICY, 3'd0, 16'(POL_BEST),    1'b0, 1'b0, 3'd0, 16'd0}
  };

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic              kind        = KIND_LOAD;
  logic [SLOT_W-1:0] slot        = '0;
  logic [SIZE_W-1:0] size        = '0;
  logic              policy_wr   = 1'b0;
  logic [1:0]        policy_data = POL_BEST;
  logic              busy;
  logic              done;
  logic              granted;
  logic [PART_W-1:0] partition;
  logic [SIZE_W-1:0] leftover;

  // tracker state: mirrors the block's capacities, pointer and fit rule
  logic [SIZE_W-1:0] cap_left [NPART];
  logic [PART_W-1:0] scan_ptr;
  logic [1:0]        fit_rule;

  alloc_result_t pending_results [$];
  int            mismatches = 0;
  int            cycles     = 0;

  partition_fit_allocator u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .slot        (slot),
    .size        (size),
    .done        (done),
    .granted     (granted),
    .partition   (partition),
    .leftover    (leftover),
    .policy_wr   (policy_wr),
    .policy_data (policy_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // picks and charges a partition for one request under the current rule
  function automatic alloc_result_t alloc_predict(input logic [SIZE_W-1:0] req);
    alloc_result_t r;
    int            pick;
    int            idx;
    pick = -1;
    r    = '0;
    if (fit_rule == POL_NEXT) begin
      // first fitting partition from the pointer, one full turn at most
      for (int i = 0; i < NPART; i++) begin
        idx = (int'(scan_ptr) + i) % NPART;
        if (pick < 0 && cap_left[idx] >= req) pick = idx;
      end
    end else begin
      for (int i = 0; i < NPART; i++) begin
        if (cap_left[i] >= req) begin
          if (pick < 0) pick = i;
          else if (fit_rule == POL_BEST && cap_left[i] < cap_left[pick]) pick = i;
          else if (fit_rule == POL_WORST && cap_left[i] > cap_left[pick]) pick = i;
        end
      end
    end
    // refused: nothing changes, all-zero result
    if (pick >= 0) begin
      cap_left[pick] = cap_left[pick] - req;
      if (fit_rule == POL_NEXT) scan_ptr = PART_W'((pick + 1) % NPART);
      r.granted   = 1'b1;
      r.partition = PART_W'(pick);
      r.leftover  = cap_left[pick];
    end
    return r;
  endfunction

  // one command transaction, optionally after an idle gap; start stays high
  // on return so back-to-back items keep it up without a glitch
  task automatic send_item(input logic k, input logic [SLOT_W-1:0] s,
                           input logic [SIZE_W-1:0] sz, input logic typed,
                           input alloc_result_t want, input int gap);
    alloc_result_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    slot  <= s;
    size  <= sz;
    do @(posedge clk); while (busy);
    // accepted at this edge
    if (k == KIND_LOAD) begin
      if (int'(s) < NPART) cap_left[s] = sz;
      scan_ptr = '0;
    end else begin
      r = alloc_predict(sz);
      pending_results.push_back(typed ? want : r);
    end
  endtask

  // hold off until every result is in and queued loads have drained
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // the fit rule only changes with nothing in flight
  task automatic write_policy(input logic [1:0] rule);
    wait_idle();
    policy_wr   <= 1'b1;
    policy_data <= rule;
    @(posedge clk);
    policy_wr <= 1'b0;
    fit_rule = rule;
  endtask

  // result checker: the receiver never stalls, so every strobe is a result
  always @(posedge clk) begin : result_check
    alloc_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: granted %0d partition %0d leftover %0d",
               granted, partition, leftover);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (granted !== e.granted) begin
          $error("granted: expected %0d, got %0d", e.granted, granted);
          mismatches++;
        end
        if (partition !== e.partition) begin
          $error("partition: expected %0d, got %0d", e.partition, partition);
          mismatches++;
        end
        if (leftover !== e.leftover) begin
          $error("leftover: expected %0d, got %0d", e.leftover, leftover);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("partition_fit_allocator: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    alloc_result_t     want;
    dir_row_t          row;
    logic              k;
    logic [SLOT_W-1:0] s;
    logic [SIZE_W-1:0] sz;
    logic [1:0]        rule;
    int                idle_pct;
    int                gap;
    int                roll;

    for (int i = 0; i < NPART; i++) cap_left[i] = '0;
    scan_ptr = '0;
    fit_rule = POL_BEST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.op == OP_POLICY) begin
        write_policy(row.size[1:0]);
      end else begin
        want = '{row.w_granted, row.w_partition, row.w_leftover};
        send_item((row.op == OP_LOAD) ? KIND_LOAD : KIND_REQ, row.slot, row.size,
                  row.typed, want, 0);
      end
    end

    // random traffic: sender idles 17%, then 76%, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 76 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        // every rule in turn first, then random ones
        rule = (seg < 4) ? 2'(seg) : 2'($urandom_range(0, 3));
        write_policy(rule);
        for (int n = 0; n < SEG_ITEMS; n++) begin
          gap  = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
          k    = ($urandom_range(0, 99) < 30) ? KIND_LOAD : KIND_REQ;
          s    = SLOT_W'($urandom_range(0, NPART - 1));
          roll = $urandom_range(0, 99);
          if (k == KIND_LOAD) begin
            // capacities mostly moderate so requests keep finding room
            if (roll < 60)      sz = SIZE_W'($urandom_range(0, 3000));
            else if (roll < 80) sz = SIZE_W'($urandom);
            else if (roll < 90) sz = '0;
            else                sz = '1;
          end else begin
            if (roll < 70)      sz = SIZE_W'($urandom_range(0, 600));
            else if (roll < 80) sz = '0;
            else if (roll < 95) sz = SIZE_W'($urandom);
            else                sz = '1;
          end
          send_item(k, s, sz, 1'b0, '0, gap);
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("partition_fit_allocator: match");
    end else begin
      $display("partition_fit_allocator: mismatch");
    end
    $finish;
  end

endmodule
